// ----- rtl/prfm_pkg.sv -----
`default_nettype none
package prfm_pkg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    localparam logic CFG_TRIP_THRESHOLD = 1'b0;
    localparam logic CFG_IGNORED_RAIL   = 1'b1;

    localparam logic [15:0] TRIP_THRESHOLD_RST = 16'd100;
    localparam logic [2:0]  IGNORED_RAIL_RST   = 3'd4;

    typedef struct packed {
        logic       operation;
        logic [2:0] rail;
    } t_in;

    typedef struct packed {
        logic        power_off;
        logic        report_valid;
        logic [2:0]  report_rail;
        logic [15:0] report_count;
        logic        bad_rail;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EV_RD,
        S_EV_WR,
        S_T_RD,
        S_T_WR,
        S_W_RD,
        S_W_CHK,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/prfm_ram.sv -----
`default_nettype none
module prfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 7
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/power_rail_fault_monitor.sv -----
`default_nettype none
// Per-rail saturating fault counters kept in two small RAMs (live count and
// snapshot), each walked one rail at a time with a read cycle followed by a
// write or check cycle. A failure event reads and writes its own rail's
// counter; a tick walks both RAMs, and a trip walks the counter RAM once
// more, where a report can wait on output stall. A bad rail or a tick
// answers with one beat that carries no report. Input is stalled while an
// item is in work; a finished beat waits in the output register without
// holding up the next input. Registers may only be written while the block
// is idle.
module power_rail_fault_monitor #(
    parameter int NUM_RAILS  = 7,
    parameter int COUNT_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire prfm_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output prfm_pkg::t_out      o_out,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_cfg_index,
    input  wire logic [15:0]    i_cfg_data
);
    import prfm_pkg::*;

    localparam int IDX_W = NUM_RAILS > 1 ? $clog2(NUM_RAILS) : 1;
    localparam int CMP_W = COUNT_BITS > 16 ? COUNT_BITS : 16;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_RAILS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_skip, n_skip;
    logic                   r_have, n_have;
    t_out                   r_res, n_res;
    t_out                   r_out;
    logic                   r_out_valid;
    logic [NUM_RAILS-1:0]   r_fvld, r_svld;
    logic [15:0]            r_thresh;
    logic [2:0]             r_ign;

    logic                   f_re, f_we, s_re, s_we;
    logic [COUNT_BITS-1:0]  f_wdata, s_wdata;
    logic [COUNT_BITS-1:0]  f_rdata, s_rdata;
    logic [COUNT_BITS-1:0]  f_q, s_q, inc, cleared;
    logic [CMP_W-1:0]       inc_w, thr_w, fq_w;
    logic                   out_free, out_load, bad, last_idx;

    prfm_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_RAILS)) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (r_idx),
        .i_wdata (f_wdata),
        .i_re    (f_re),
        .i_raddr (r_idx),
        .o_rdata (f_rdata)
    );

    prfm_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_RAILS)) u_snap_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_idx),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (r_idx),
        .o_rdata (s_rdata)
    );

    // entries never written read as zero
    assign f_q      = r_fvld[r_idx] ? f_rdata : '0;
    assign s_q      = r_svld[r_idx] ? s_rdata : '0;
    assign inc      = (f_q == CNT_MAX) ? f_q : f_q + COUNT_BITS'(1);
    assign cleared  = (f_q == s_q) ? '0 : f_q;
    assign inc_w    = CMP_W'(inc);
    assign thr_w    = CMP_W'(r_thresh);
    assign fq_w     = CMP_W'(f_q);
    assign bad      = {2'b00, i_in.rail} >= 5'(NUM_RAILS);
    assign last_idx = r_idx == IDX_LAST;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_skip   = r_skip;
        n_have   = r_have;
        n_res    = r_res;
        f_re     = 1'b0;
        s_re     = 1'b0;
        f_we     = 1'b0;
        s_we     = 1'b0;
        f_wdata  = inc;
        s_wdata  = cleared;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    if (i_in.operation == OP_TICK) begin
                        n_idx   = '0;
                        n_state = S_T_RD;
                    end else if (bad) begin
                        n_res.bad_rail = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        n_idx   = IDX_W'(i_in.rail);
                        n_skip  = i_in.rail == r_ign;
                        n_state = S_EV_RD;
                    end
                end
            end
            S_EV_RD: begin
                f_re    = 1'b1;
                n_state = S_EV_WR;
            end
            S_EV_WR: begin
                f_we = 1'b1;
                if (!r_skip && inc_w >= thr_w) begin
                    n_idx   = '0;
                    n_have  = 1'b0;
                    n_state = S_W_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_T_RD: begin
                f_re    = 1'b1;
                s_re    = 1'b1;
                n_state = S_T_WR;
            end
            S_T_WR: begin
                f_we    = 1'b1;
                s_we    = 1'b1;
                f_wdata = cleared;
                if (last_idx) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_T_RD;
                end
            end
            S_W_RD: begin
                f_re    = 1'b1;
                n_state = S_W_CHK;
            end
            S_W_CHK: begin
                // one report is held back so the final one can be marked last
                if (!(f_q != '0 && r_have && !out_free)) begin
                    if (f_q != '0) begin
                        out_load           = r_have;
                        n_have             = 1'b1;
                        n_res.power_off    = 1'b1;
                        n_res.report_valid = 1'b1;
                        n_res.report_rail  = 3'(r_idx);
                        n_res.report_count = fq_w[15:0];
                        n_res.bad_rail     = 1'b0;
                        n_res.last         = 1'b0;
                    end
                    if (last_idx) begin
                        n_res.last = 1'b1;
                        n_state    = S_EMIT;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_W_RD;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_skip      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_fvld      <= '0;
            r_svld      <= '0;
            r_thresh    <= TRIP_THRESHOLD_RST;
            r_ign       <= IGNORED_RAIL_RST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_skip  <= n_skip;
            r_have  <= n_have;
            if (f_we) begin
                r_fvld[r_idx] <= 1'b1;
            end
            if (s_we) begin
                r_svld[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TRIP_THRESHOLD: r_thresh <= i_cfg_data;
                    CFG_IGNORED_RAIL:   r_ign    <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

endmodule
`default_nettype wire

// ----- sim/fault_report_checker.sv -----
`timescale 1ns / 100ps
module fault_report_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_stall,
    input  wire prfm_pkg::t_in   i_in,
    input  wire logic            i_out_valid,
    input  wire logic            i_out_stall,
    input  wire prfm_pkg::t_out  i_out,
    input  wire logic            i_cfg_valid,
    input  wire logic            i_cfg_ready,
    input  wire logic            i_cfg_index,
    input  wire logic [15:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_trips
);
    import prfm_pkg::*;

    localparam int          RAILS     = 7;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    logic [15:0] rail_count [RAILS];
    logic [15:0] rail_snap  [RAILS];
    logic [15:0] trip_level;
    logic [2:0]  skip_rail;

    t_out expected_reports [$];
    int   err_total;
    int   result_total;
    int   trip_total;

    initial begin
        err_total    = 0;
        result_total = 0;
        trip_total   = 0;
    end

    // advance the counter model by one input beat and queue what it must produce
    task automatic predict_item(input t_in item);
        t_out r;
        int   i;
        int   nonzero;
        int   k;
        r = '0;
        if (item.operation == OP_TICK) begin
            for (i = 0; i < RAILS; i++) begin
                if (rail_count[i] == rail_snap[i])
                    rail_count[i] = '0;
                rail_snap[i] = rail_count[i];
            end
            r.last = 1'b1;
            expected_reports.push_back(r);
        end else if (int'(item.rail) >= RAILS) begin
            r.bad_rail = 1'b1;
            r.last     = 1'b1;
            expected_reports.push_back(r);
        end else begin
            if (rail_count[item.rail] != COUNT_TOP)
                rail_count[item.rail] = rail_count[item.rail] + 16'd1;
            if (item.rail == skip_rail || rail_count[item.rail] < trip_level) begin
                r.last = 1'b1;
                expected_reports.push_back(r);
            end else begin
                trip_total++;
                nonzero = 0;
                for (i = 0; i < RAILS; i++)
                    if (rail_count[i] != '0)
                        nonzero++;
                k = 0;
                for (i = 0; i < RAILS; i++) begin
                    if (rail_count[i] != '0) begin
                        r.power_off    = 1'b1;
                        r.report_valid = 1'b1;
                        r.report_rail  = 3'(i);
                        r.report_count = rail_count[i];
                        r.last         = (k == nonzero - 1);
                        expected_reports.push_back(r);
                        k++;
                    end
                end
            end
        end
    endtask

    task automatic check_beat(input t_out got);
        t_out want;
        result_total++;
        if (expected_reports.size() == 0) begin
            err_total++;
            if (err_total <= 10)
                $display("unexpected result beat at %0t: %s%0d %s%0d %s%0d %s%0d %s%0d %s%0d",
                         $realtime, "off=", got.power_off, "rep=", got.report_valid,
                         "rail=", got.report_rail, "cnt=", got.report_count,
                         "bad=", got.bad_rail, "last=", got.last);
        end else begin
            want = expected_reports.pop_front();
            if (got.power_off !== want.power_off || got.report_valid !== want.report_valid ||
                got.report_rail !== want.report_rail ||
                got.report_count !== want.report_count ||
                got.bad_rail !== want.bad_rail || got.last !== want.last) begin
                err_total++;
                if (err_total <= 10) begin
                    $display("mismatch at %0t: expected off=%0d rep=%0d rail=%0d %s%0d %s%0d %s%0d",
                             $realtime, want.power_off, want.report_valid,
                             want.report_rail, "cnt=", want.report_count,
                             "bad=", want.bad_rail, "last=", want.last);
                    $display("             got      off=%0d rep=%0d rail=%0d %s%0d %s%0d %s%0d",
                             got.power_off, got.report_valid, got.report_rail,
                             "cnt=", got.report_count, "bad=", got.bad_rail,
                             "last=", got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RAILS; i++) begin
                rail_count[i] = '0;
                rail_snap[i]  = '0;
            end
            trip_level = TRIP_THRESHOLD_RST;
            skip_rail  = IGNORED_RAIL_RST;
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TRIP_THRESHOLD: trip_level = i_cfg_data;
                    CFG_IGNORED_RAIL:   skip_rail  = i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            // results always belong to earlier beats, so pop before push
            if (i_out_valid && !i_out_stall)
                check_beat(i_out);
            if (i_in_valid && !i_in_stall)
                predict_item(i_in);
        end
        o_errors  <= err_total;
        o_pending <= expected_reports.size();
        o_results <= result_total;
        o_trips   <= trip_total;
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
    import prfm_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 68;
    localparam int SETTLE       = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_beat;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_TRIP_THRESHOLD;
    logic [15:0] cfg_data = '0;

    int errors;
    int pending;
    int results;
    int trips;

    int beats_in = 0;
    int reg_writes = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    always #4 clk = ~clk;

    power_rail_fault_monitor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fault_report_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_trips     (trips)
    );

    // valid stays high on return so a back-to-back beat needs no second assignment
    task automatic send_item(input logic op, input logic [2:0] rail);
        t_in b;
        b.operation = op;
        b.rail      = rail;
        in_beat  <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        beats_in++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_limits(input logic [15:0] thr, input logic [2:0] ign);
        write_reg(CFG_TRIP_THRESHOLD, thr);
        // upper data bits are don't-care for the ignored rail
        write_reg(CFG_IGNORED_RAIL, {13'($urandom), ign});
    endtask

    function automatic t_in pick_fault_item();
        t_in b;
        int  r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            b.operation = OP_TICK;
            b.rail      = 3'($urandom);
        end else if (r < 23) begin
            b.operation = OP_EVENT;
            b.rail      = 3'd7;
        end else begin
            b.operation = OP_EVENT;
            b.rail      = 3'($urandom_range(0, 6));
        end
        return b;
    endfunction

    // output side: random stall bursts, quiet stretches, one long hold-off on request
    initial begin
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
                @(posedge clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial begin
        t_in b;
        logic [15:0] thr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: tick on empty counters, bad rail, tick with rail field set
        send_item(OP_TICK, 3'd0);
        send_item(OP_EVENT, 3'd7);
        send_item(OP_TICK, 3'd7);

        // threshold 1, nothing ignored: trips grow to a report on every rail
        set_limits(16'd1, 3'd7);
        send_item(OP_EVENT, 3'd0);
        send_item(OP_EVENT, 3'd6);
        for (int r = 1; r <= 5; r++)
            send_item(OP_EVENT, 3'(r));
        send_item(OP_TICK, 3'd2);
        send_item(OP_TICK, 3'd5);
        send_item(OP_EVENT, 3'd7);

        // zero threshold trips on any counted rail, except the ignored one
        set_limits(16'd0, 3'd3);
        send_item(OP_EVENT, 3'd3);
        send_item(OP_EVENT, 3'd2);
        set_limits(16'hFFFF, 3'd0);
        send_item(OP_EVENT, 3'd0);
        send_item(OP_EVENT, 3'd1);
        send_item(OP_TICK, 3'd0);
        send_item(OP_TICK, 3'd0);

        // single trip and two ticks with the output never stalled
        calm = 1'b1;
        set_limits(16'd1, 3'd7);
        send_item(OP_EVENT, 3'd2);
        send_item(OP_TICK, 3'd0);
        send_item(OP_TICK, 3'd0);
        calm = 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: thr = 16'd4;
                1: thr = 16'($urandom_range(1, 3));
                2: thr = 16'd0;
                3: thr = 16'($urandom);
                4: thr = 16'($urandom_range(2, 6));
                default: thr = 16'($urandom_range(1, 5));
            endcase
            if (ph == PHASES - 1)
                calm = 1'b1;
            set_limits(thr, (ph == 1) ? 3'd7 : 3'($urandom_range(0, 7)));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 10)
                    hold_req = 1'b1;
                if ((ph == 2 && k == 36) || (ph == 4 && k == 50))
                    drain();
                b = pick_fault_item();
                send_item(b.operation, b.rail);
                // no gaps while the long hold-off is filling the block
                if (!calm && !hold_req && $urandom_range(0, 3) == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge clk);
                end
            end
        end

        drain();
        repeat (40) @(posedge clk);
        $display("covered %0d input beats, %0d result beats and %0d trips",
                 beats_in, results, trips);
        $display("over %0d register writes, thresholds 0, 1 and 65535, no rail ignored",
                 reg_writes);
        if (errors == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
